@@ rtl/directed_triangle_finder_unit_defines.svh @@
// Assertion macros for the directed triangle finder.
`ifndef DIRECTED_TRIANGLE_FINDER_UNIT_DEFINES_SVH
`define DIRECTED_TRIANGLE_FINDER_UNIT_DEFINES_SVH

// Plain property, clocked on clk_i, off while rst_ni is low.
`define DTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define DTF_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ rtl/dtf_pkg.sv @@
// Shared types and constants of the directed triangle finder.
package dtf_pkg;

  localparam int unsigned ROW_W         = 64;
  localparam int unsigned NODE_W        = 6;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned MIN_NODES     = 3;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [2:0] {
    S_LOAD,
    S_COL,
    S_COLEND,
    S_MID,
    S_MIDEND,
    S_FIN
  } dtf_state_e;

  typedef struct packed {
    logic              hit;
    logic [NODE_W-1:0] node;
  } dtf_hit_t;

endpackage

@@ rtl/dtf_cfg_if.sv @@
// Configuration write channel carrying node_count.
interface dtf_cfg_if;
  import dtf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] node_count;

  modport source (output valid, output node_count, input ready);
  modport sink (input valid, input node_count, output ready);
endinterface

@@ rtl/dtf_row_if.sv @@
// Input channel carrying one adjacency row per beat.
interface dtf_row_if;
  import dtf_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row_bits;
  logic [NODE_W-1:0] row_index;

  modport source (output valid, output row_bits, output row_index, input ready);
  modport sink (input valid, input row_bits, input row_index, output ready);
endinterface

@@ rtl/dtf_res_if.sv @@
// Result channel carrying the found flag and the cycle nodes.
interface dtf_res_if;
  import dtf_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;
  logic [NODE_W-1:0] third_node;

  modport source (output valid, output found, output first_node, output second_node,
                  output third_node, input ready);
  modport sink (input valid, input found, input first_node, input second_node,
                input third_node, output ready);
endinterface

@@ rtl/dtf_row_mem.sv @@
// Adjacency row store: one write port, one registered read port.
module dtf_row_mem #(
  parameter int unsigned DEPTH = dtf_pkg::MAX_NODES_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [dtf_pkg::ROW_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [dtf_pkg::ROW_W-1:0] rdata_o
);
  import dtf_pkg::*;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/dtf_cand_unit.sv @@
// Closing-node test: masks row(b) & column(a), picks the lowest candidate.
module dtf_cand_unit (
  input  logic [dtf_pkg::ROW_W-1:0]  row_i,
  input  logic [dtf_pkg::ROW_W-1:0]  col_i,
  input  logic [dtf_pkg::ROW_W-1:0]  mask_i,
  input  logic [dtf_pkg::NODE_W-1:0] a_i,
  input  logic [dtf_pkg::NODE_W-1:0] b_i,
  output dtf_pkg::dtf_hit_t          hit_o
);
  import dtf_pkg::*;

  logic [ROW_W-1:0] cand;

  always_comb begin
    cand = row_i & col_i & mask_i;
    cand[a_i] = 1'b0;
    cand[b_i] = 1'b0;
    hit_o.hit  = |cand;
    hit_o.node = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_o.node = NODE_W'(i);
      end
    end
  end
endmodule

@@ rtl/directed_triangle_finder_unit.sv @@
// Top level of the directed triangle finder: sequencer, column builder, result register.
//
// Usage:
//   cfg_i  : write node_count (3..64, clamped) while idle; always ready.
//   row_i  : one adjacency row per beat; row_index selects the node. A row is
//            taken every cycle while loading. The beat that brings the count of
//            rows to the clamped node_count or past it starts a search and drops row_i.ready.
//   res_o  : one beat per graph: found flag and nodes a, b, c (zeros if none).
// The search is n passes, one per start node a, and ends early when a cycle is
//   found. Each pass sweeps the row memory read port twice: once to build
//   column a, once over middle nodes b. No rows are taken while a search runs.
// The result sits in an output register; loading of the next graph proceeds
// while it waits. If res_o stalls and a second search ends, the block holds
// the new result and keeps row_i.ready low until the register frees.
// Reset: node_count returns to 64, the row count to zero, no result pending.
// Stored rows are not cleared; every row a search reads must have been written.
`include "directed_triangle_finder_unit_defines.svh"

module directed_triangle_finder_unit #(
  parameter int unsigned MAX_NODES = dtf_pkg::MAX_NODES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dtf_cfg_if.sink  cfg_i,
  dtf_row_if.sink  row_i,
  dtf_res_if.source res_o
);
  import dtf_pkg::*;

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(MAX_NODES);

  dtf_state_e        state_q, state_d;
  logic [CNT_W-1:0]  node_count_q;
  logic [CNT_W-1:0]  rows_q, rows_d;
  logic [AW-1:0]     a_q, a_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     lag_q;
  logic              lag_vld_q, lag_col_q;
  logic              issue;
  logic [MAX_NODES-1:0] col_q, col_d;
  logic [ROW_W-1:0]  nexts_q, nexts_d;
  logic              fnd_q, fnd_d;
  logic [NODE_W-1:0] fb_q, fb_d, fc_q, fc_d;
  logic              res_vld_q, res_vld_d;
  logic              res_found_q, res_found_d;
  logic [NODE_W-1:0] res_a_q, res_a_d, res_b_q, res_b_d, res_c_q, res_c_d;

  logic [CNT_W-1:0]  n_eff;
  logic [AW-1:0]     n_last;
  logic [ROW_W-1:0]  mask;
  logic              in_acc;
  logic              mem_we;
  logic [ROW_W-1:0]  rdata;
  logic [NODE_W-1:0] a6, b6;
  dtf_hit_t          cu_hit;
  logic              hit_now;

  always_comb begin
    if (node_count_q < CNT_W'(MIN_NODES)) begin
      n_eff = CNT_W'(MIN_NODES);
    end else if (node_count_q > NMAX) begin
      n_eff = NMAX;
    end else begin
      n_eff = node_count_q;
    end
  end

  assign n_last = AW'(n_eff - CNT_W'(1));
  assign mask   = {ROW_W{1'b1}} >> (CNT_W'(ROW_W) - n_eff);

  assign cfg_i.ready = 1'b1;
  assign row_i.ready = (state_q == S_LOAD);
  assign in_acc      = row_i.valid && row_i.ready;
  assign mem_we      = in_acc && ({1'b0, row_i.row_index} < NMAX);

  dtf_row_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(row_i.row_index)),
    .wdata_i (row_i.row_bits),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  assign a6 = NODE_W'(a_q);
  assign b6 = NODE_W'(lag_q);

  dtf_cand_unit u_cand (
    .row_i  (rdata),
    .col_i  (ROW_W'(col_q)),
    .mask_i (mask),
    .a_i    (a6),
    .b_i    (b6),
    .hit_o  (cu_hit)
  );

  assign hit_now = lag_vld_q && !lag_col_q && nexts_q[b6] && (b6 != a6) && cu_hit.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      node_count_q <= NODE_COUNT_RST;
      rows_q       <= '0;
      a_q          <= '0;
      cnt_q        <= '0;
      lag_vld_q    <= 1'b0;
      lag_col_q    <= 1'b0;
      fnd_q        <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      a_q       <= a_d;
      cnt_q     <= cnt_d;
      lag_vld_q <= issue;
      lag_col_q <= (state_q == S_COL);
      fnd_q     <= fnd_d;
      res_vld_q <= res_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        node_count_q <= cfg_i.node_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lag_q       <= cnt_q;
    col_q       <= col_d;
    nexts_q     <= nexts_d;
    fb_q        <= fb_d;
    fc_q        <= fc_d;
    res_found_q <= res_found_d;
    res_a_q     <= res_a_d;
    res_b_q     <= res_b_d;
    res_c_q     <= res_c_d;
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    a_d         = a_q;
    cnt_d       = cnt_q;
    issue       = 1'b0;
    col_d       = col_q;
    nexts_d     = nexts_q;
    fnd_d       = fnd_q;
    fb_d        = fb_q;
    fc_d        = fc_q;
    res_vld_d   = res_vld_q && !res_o.ready;
    res_found_d = res_found_q;
    res_a_d     = res_a_q;
    res_b_d     = res_b_q;
    res_c_d     = res_c_q;

    if (lag_vld_q && lag_col_q) begin
      col_d[lag_q] = rdata[a6];
      if (lag_q == a_q) begin
        nexts_d = rdata;
      end
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if ((rows_q + CNT_W'(1)) >= n_eff) begin
            rows_d  = '0;
            a_d     = '0;
            cnt_d   = '0;
            state_d = S_COL;
          end else begin
            rows_d = rows_q + CNT_W'(1);
          end
        end
      end
      S_COL: begin
        issue = 1'b1;
        if (cnt_q == n_last) begin
          cnt_d   = '0;
          state_d = S_COLEND;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_COLEND: begin
        state_d = S_MID;
      end
      S_MID: begin
        issue = 1'b1;
        if (hit_now) begin
          fnd_d   = 1'b1;
          fb_d    = b6;
          fc_d    = cu_hit.node;
          cnt_d   = '0;
          state_d = S_FIN;
        end else if (cnt_q == n_last) begin
          cnt_d   = '0;
          state_d = S_MIDEND;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_MIDEND: begin
        if (hit_now) begin
          fnd_d   = 1'b1;
          fb_d    = b6;
          fc_d    = cu_hit.node;
          state_d = S_FIN;
        end else if (a_q == n_last) begin
          fnd_d   = 1'b0;
          state_d = S_FIN;
        end else begin
          a_d     = a_q + AW'(1);
          state_d = S_COL;
        end
      end
      S_FIN: begin
        if (!res_vld_q || res_o.ready) begin
          res_vld_d   = 1'b1;
          res_found_d = fnd_q;
          res_a_d     = fnd_q ? a6 : '0;
          res_b_d     = fnd_q ? fb_q : '0;
          res_c_d     = fnd_q ? fc_q : '0;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.found       = res_found_q;
  assign res_o.first_node  = res_a_q;
  assign res_o.second_node = res_b_q;
  assign res_o.third_node  = res_c_q;

  `DTF_ASSERT_IMPL(a_res_distinct, res_vld_q && res_found_q,
    (res_a_q != res_b_q) && (res_b_q != res_c_q) && (res_a_q != res_c_q),
    "found cycle has repeated nodes")
  `DTF_ASSERT_IMPL(a_res_zero, res_vld_q && !res_found_q,
    (res_a_q == '0) && (res_b_q == '0) && (res_c_q == '0),
    "empty result carries nonzero nodes")
  `DTF_ASSERT(a_rows_bound, rows_q < NMAX, "row count reached node limit")
  `DTF_ASSERT_IMPL(a_lag_range, lag_vld_q, lag_q <= n_last, "read beyond node count")
endmodule

@@ dv/dtf_triangle_monitor.sv @@
// Monitor for the directed triangle finder: predicts each graph's cycle and checks res beats.
module dtf_triangle_monitor #(
  parameter int unsigned MAX_NODES = dtf_pkg::MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtf_cfg_if          cfg_i,
  dtf_row_if          row_i,
  dtf_res_if          res_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned cycles_found_o
);
  import dtf_pkg::*;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic [NODE_W-1:0] third_node;
  } triangle_t;

  logic [ROW_W-1:0] adj_rows [64];
  logic [CNT_W-1:0] node_count_q;
  logic [CNT_W-1:0] rows_loaded_q;
  triangle_t        expected_q [$];
  int unsigned      mismatch_cnt;
  int unsigned      result_cnt;
  int unsigned      cycle_cnt;

  function automatic int unsigned effective_nodes(logic [CNT_W-1:0] setting);
    if (setting < MIN_NODES) return MIN_NODES;
    if (setting > MAX_NODES) return MAX_NODES;
    return setting;
  endfunction

  // a ascending, then b ascending, lowest c closing b->c->a
  function automatic triangle_t search_triangle(int unsigned n);
    triangle_t        hit;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] nexts;
    logic [ROW_W-1:0] col_a;
    logic [ROW_W-1:0] cand;
    int unsigned      a;
    int unsigned      b;
    int unsigned      r;
    int unsigned      c;
    hit  = '0;
    mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (a = 0; a < n; a++) begin
      for (r = 0; r < 64; r++) col_a[r] = adj_rows[r][a];
      nexts    = adj_rows[a] & mask;
      nexts[a] = 1'b0;
      for (b = 0; b < n; b++) begin
        if (nexts[b]) begin
          cand    = adj_rows[b] & col_a & mask;
          cand[a] = 1'b0;
          cand[b] = 1'b0;
          if (cand != '0) begin
            c = 0;
            while (c < 63 && !cand[c]) c++;
            hit.found       = 1'b1;
            hit.first_node  = NODE_W'(a);
            hit.second_node = NODE_W'(b);
            hit.third_node  = NODE_W'(c);
            return hit;
          end
        end
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    triangle_t got;
    triangle_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) adj_rows[i] = '0;
      node_count_q   = NODE_COUNT_RST;
      rows_loaded_q  = '0;
      expected_q.delete();
      mismatch_cnt   = 0;
      result_cnt     = 0;
      cycle_cnt      = 0;
      mismatches_o   <= 0;
      pending_o      <= 0;
      results_o      <= 0;
      cycles_found_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.found, res_i.first_node, res_i.second_node, res_i.third_node};
        result_cnt++;
        if (got.found) cycle_cnt++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: found=%0d a=%0d b=%0d c=%0d",
                 got.found, got.first_node, got.second_node, got.third_node);
          mismatch_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatch_cnt++;
          end
          if (got.first_node !== want.first_node) begin
            $error("first_node: expected %0d, got %0d", want.first_node, got.first_node);
            mismatch_cnt++;
          end
          if (got.second_node !== want.second_node) begin
            $error("second_node: expected %0d, got %0d", want.second_node, got.second_node);
            mismatch_cnt++;
          end
          if (got.third_node !== want.third_node) begin
            $error("third_node: expected %0d, got %0d", want.third_node, got.third_node);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) node_count_q = cfg_i.node_count;
      if (row_i.valid && row_i.ready) begin
        adj_rows[row_i.row_index] = row_i.row_bits;
        rows_loaded_q = rows_loaded_q + 1'b1;
        if (rows_loaded_q >= effective_nodes(node_count_q)) begin
          rows_loaded_q = '0;
          expected_q = {expected_q, search_triangle(effective_nodes(node_count_q))};
        end
      end
      mismatches_o   <= mismatch_cnt;
      pending_o      <= expected_q.size();
      results_o      <= result_cnt;
      cycles_found_o <= cycle_cnt;
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Top of the directed triangle finder testbench: clock, reset, row and config stimulus, verdict.
module tb_top;
  import dtf_pkg::*;

  localparam int unsigned RANDOM_ROWS = 280;
  localparam int unsigned HOLD_CYCLES = 500;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned cycles_found;
  int unsigned rows_sent     = 0;
  int unsigned cfg_writes    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  bit          sender_calm   = 1'b0;
  bit          rx_calm       = 1'b0;

  dtf_cfg_if cfg_bus ();
  dtf_row_if row_bus ();
  dtf_res_if res_bus ();

  directed_triangle_finder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .row_i  (row_bus),
    .res_o  (res_bus)
  );

  dtf_triangle_monitor triangle_mon (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_i          (cfg_bus),
    .row_i          (row_bus),
    .res_i          (res_bus),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .results_o      (results),
    .cycles_found_o (cycles_found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_row(input logic [ROW_W-1:0] bits, input logic [NODE_W-1:0] idx);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      row_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_bus.valid     <= 1'b1;
    row_bus.row_bits  <= bits;
    row_bus.row_index <= idx;
    @(posedge clk);
    while (!row_bus.ready) @(posedge clk);
    rows_sent++;
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] setting);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.node_count <= setting;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic wait_drain();
    row_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one graph of n rows; a broken one swaps some beats for random index and content
  task automatic send_graph(input int unsigned n, input bit broken);
    int unsigned      order [64];
    logic [ROW_W-1:0] rows [64];
    int unsigned      pct;
    int unsigned      k;
    int unsigned      j;
    int unsigned      tmp;
    int unsigned      x;
    int unsigned      y;
    int unsigned      z;
    for (k = 0; k < n; k++) order[k] = k;
    for (k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    case ($urandom_range(0, 3))
      0: pct = 5;
      1: pct = 15;
      2: pct = 35;
      default: pct = 70;
    endcase
    if (n > 24) pct = $urandom_range(1, 5);
    for (k = 0; k < n; k++) begin
      for (j = 0; j < 64; j++)
        rows[k][j] = (j < n) ? ($urandom_range(0, 99) < pct) : 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 1)) begin
      x = $urandom_range(0, n - 1);
      y = (x + $urandom_range(1, n - 1)) % n;
      do z = $urandom_range(0, n - 1); while (z == x || z == y);
      rows[x][y] = 1'b1;
      rows[y][z] = 1'b1;
      rows[z][x] = 1'b1;
    end
    for (k = 0; k < n; k++) begin
      if (broken && $urandom_range(0, 99) < 40)
        send_row({$urandom, $urandom}, NODE_W'($urandom_range(0, 63)));
      else
        send_row(rows[order[k]], NODE_W'(order[k]));
    end
  endtask

  initial begin
    int unsigned stall_len;
    res_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_requests != holds_done) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        res_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall_len = rx_calm ? 0 : pick_gap();
        if (stall_len != 0) begin
          res_bus.ready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] setting;
    int unsigned      pick;
    int unsigned      graphs;
    int unsigned      nodes;
    int unsigned      random_start;
    int unsigned      phase;
    bit               big_done;
    rst_n              <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.node_count <= '0;
    row_bus.valid      <= 1'b0;
    row_bus.row_bits   <= '0;
    row_bus.row_index  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // node count below range acts as 3; all-ones row, self loop, bits past the count
    write_node_count(7'd0);
    send_row('1, 6'd0);
    send_row(64'h4, 6'd1);
    send_row(64'h1, 6'd2);
    // row 63 stored and counted but outside the search
    send_row(64'h8000_0000_0000_0001, 6'd0);
    send_row('1, 6'd63);
    send_row(64'h0, 6'd1);
    wait_drain();
    // repeated row index: later row wins
    write_node_count(7'd2);
    send_row(64'h4, 6'd1);
    send_row(64'h2, 6'd0);
    send_row(64'h0, 6'd2);
    send_row(64'h2, 6'd2);
    send_row(64'h1, 6'd2);
    send_row(64'h6, 6'd0);
    wait_drain();
    // cycle starting past node 0
    write_node_count(7'd4);
    send_row(64'h1, 6'd0);
    send_row(64'h8, 6'd1);
    send_row(64'h2, 6'd2);
    send_row(64'h6, 6'd3);
    wait_drain();
    // count lowered mid-load: next row fires the search
    write_node_count(7'd8);
    send_row(64'h4, 6'd0);
    send_row(64'h1, 6'd1);
    send_row(64'h2, 6'd2);
    send_row(64'hF0, 6'd3);
    wait_drain();
    write_node_count(7'd3);
    send_row(64'h2, 6'd2);
    wait_drain();

    // full 64-node graph, clamped from the top setting; writes every row
    write_node_count(7'd127);
    send_graph(64, 1'b0);
    wait_drain();

    // long receiver hold while rows keep coming
    write_node_count(7'd3);
    sender_calm = 1'b1;
    rx_calm     = 1'b1;
    hold_requests++;
    repeat (8) send_graph(3, 1'b0);
    wait_drain();

    random_start = rows_sent;
    phase        = 0;
    big_done     = 1'b0;
    while (rows_sent < random_start + RANDOM_ROWS) begin
      pick   = $urandom_range(0, 99);
      graphs = $urandom_range(1, 6);
      if ((pick < 5 || phase == 6) && !big_done) begin
        setting  = $urandom_range(0, 1) ? 7'd64 : CNT_W'($urandom_range(65, 127));
        graphs   = 1;
        big_done = 1'b1;
      end else if (pick < 15) begin
        setting = CNT_W'($urandom_range(0, 2));
      end else if (pick < 27) begin
        setting = CNT_W'($urandom_range(11, 24));
      end else begin
        setting = CNT_W'($urandom_range(3, 10));
      end
      nodes = (setting < MIN_NODES) ? MIN_NODES : ((setting > 64) ? 64 : setting);
      wait_drain();
      write_node_count(setting);
      sender_calm = ($urandom_range(0, 3) == 0);
      rx_calm     = ($urandom_range(0, 3) == 0);
      repeat (graphs) send_graph(nodes, $urandom_range(0, 99) < 15);
      phase++;
    end

    wait_drain();
    repeat (50) @(posedge clk);
    $display("tb_top: %0d rows, %0d node_count writes, %0d graphs checked, %0d with a cycle",
             rows_sent, cfg_writes, results, cycles_found);
    $display("tb_top: node counts 3..64 with clamped settings, broken row runs, long res stall");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dtf_pkg.sv
rtl/dtf_cfg_if.sv
rtl/dtf_row_if.sv
rtl/dtf_res_if.sv
rtl/dtf_row_mem.sv
rtl/dtf_cand_unit.sv
rtl/directed_triangle_finder_unit.sv
dv/dtf_triangle_monitor.sv
dv/tb_top.sv
